// ===== rtl/core/corner_chord_tap_hold_resolver_macros.svh =====
// Assertion macros shared by the resolver's checker.
// No dependencies; include by bare file name.
`ifndef CORNER_CHORD_TAP_HOLD_RESOLVER_MACROS_SVH
`define CORNER_CHORD_TAP_HOLD_RESOLVER_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define CCTHR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("resolver check failed");

// Next-cycle implication, masked while reset is high.
`define CCTHR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("resolver check failed");

// Implication that also runs across reset.
`define CCTHR_ASSERT_RAW(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("resolver check failed");

`endif

// ===== rtl/core/ccthr_pkg.sv =====
// Types, codes and helpers for the corner chord tap/hold resolver.
// No dependencies; used by the top level and its checker.
package ccthr_pkg;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PENDING,
      PH_HELD
   } phase_type;

   typedef enum logic [1:0] {
      OP_PRESS,
      OP_RELEASE,
      OP_TICK
   } opcode_type;

   typedef enum logic [1:0] {
      ACT_TAP,
      ACT_REG,
      ACT_UNREG,
      ACT_TOGGLE
   } action_type;

   typedef struct packed {
      logic        corner;
      action_type  action;
      logic [15:0] code;
   } rsp_type;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_CHORD_TICKS = 2'd0;
   localparam logic [1:0] REG_MINUS_CODE  = 2'd1;
   localparam logic [1:0] REG_UNDER_CODE  = 2'd2;

   localparam logic [15:0] CHORD_TICKS_RST = 16'd50;
   localparam logic [15:0] MINUS_CODE_RST  = 16'd45;
   localparam logic [15:0] UNDER_CODE_RST  = 16'd557;

   localparam int          QUEUE_DEPTH = 2;

   // caps word swaps minus for underscore
   function automatic logic [15:0] send_code(input logic [15:0] code,
                                             input logic        caps,
                                             input logic [15:0] minus,
                                             input logic [15:0] under);
      return (caps && code == minus) ? under : code;
   endfunction

endpackage

// ===== rtl/core/corner_chord_tap_hold_resolver.sv =====
// Corner chord tap/hold resolver: two corner keys, chord toggle, tap/hold timing.
// Depends on ccthr_pkg.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+------------------------------------------
//   req_     | in  | tvalid/tready       | tdata: key_code, caps_word; tuser: opcode, corner
//   rsp_     | out | tvalid/tready       | tdata: out_code; tuser: action, out_corner
//   csr_     | in  | psel/penable/pready | chord_ticks, minus_code, underscore_code
//
// One request per cycle while req_tready is high. Its result (if any) is registered into
// a two-entry output queue and reaches rsp_ behind older results; req_tready drops only
// while both entries hold results, so a stalled rsp_ side still lets one more request in.
// Synchronous reset clears corner state, empties the queue and loads the CSR reset values.
module corner_chord_tap_hold_resolver (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] key_code, [16] caps_word, [23:17] zero
   input  logic [2:0]  req_tuser,   // [1:0] opcode, [2] corner
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_code
   output logic [2:0]  rsp_tuser,   // [1:0] action, [2] out_corner
   // CSR port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------------------------------------------------------
   // CSRs
   // ---------------------------------------------------------------
   logic [15:0] chord_ticks_ff, chord_ticks_in;
   logic [15:0] minus_code_ff,  minus_code_in;
   logic [15:0] under_code_ff,  under_code_in;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      chord_ticks_in = chord_ticks_ff;
      minus_code_in  = minus_code_ff;
      under_code_in  = under_code_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            ccthr_pkg::REG_CHORD_TICKS: chord_ticks_in = csr_pwdata[15:0];
            ccthr_pkg::REG_MINUS_CODE:  minus_code_in  = csr_pwdata[15:0];
            ccthr_pkg::REG_UNDER_CODE:  under_code_in  = csr_pwdata[15:0];
            default: ;  // unmapped: dropped
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         ccthr_pkg::REG_CHORD_TICKS: csr_prdata = {16'd0, chord_ticks_ff};
         ccthr_pkg::REG_MINUS_CODE:  csr_prdata = {16'd0, minus_code_ff};
         ccthr_pkg::REG_UNDER_CODE:  csr_prdata = {16'd0, under_code_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chord_ticks_ff <= ccthr_pkg::CHORD_TICKS_RST;
         minus_code_ff  <= ccthr_pkg::MINUS_CODE_RST;
         under_code_ff  <= ccthr_pkg::UNDER_CODE_RST;
      end else begin
         chord_ticks_ff <= chord_ticks_in;
         minus_code_ff  <= minus_code_in;
         under_code_ff  <= under_code_in;
      end
   end

   // ---------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------
   ccthr_pkg::opcode_type req_op;
   logic        req_corner;
   logic        req_other;
   logic [15:0] req_code;
   logic        req_caps;
   logic        req_accept;

   assign req_op     = ccthr_pkg::opcode_type'(req_tuser[1:0]);
   assign req_corner = req_tuser[2];
   assign req_other  = ~req_tuser[2];
   assign req_code   = req_tdata[15:0];
   assign req_caps   = req_tdata[16];
   assign req_accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------
   // Per-corner state
   // ---------------------------------------------------------------
   ccthr_pkg::phase_type phase_ff [2];
   ccthr_pkg::phase_type phase_in [2];
   logic [15:0] wait_ff    [2];
   logic [15:0] wait_in    [2];
   logic [15:0] pending_ff [2];
   logic [15:0] pending_in [2];
   logic [15:0] held_ff    [2];
   logic [15:0] held_in    [2];

   logic               res_valid;   // this request produces a result
   ccthr_pkg::rsp_type res;
   logic               tick_done;   // one hold resolves per tick
   logic [15:0]        load_ticks;

   // zero chord_ticks behaves like one
   assign load_ticks = (chord_ticks_ff == 16'd0) ? 16'd1 : chord_ticks_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         phase_in[i]   = phase_ff[i];
         wait_in[i]    = wait_ff[i];
         pending_in[i] = pending_ff[i];
         held_in[i]    = held_ff[i];
      end
      res_valid  = 1'b0;
      res        = '0;
      tick_done  = 1'b0;

      case (req_op)
         ccthr_pkg::OP_PRESS: begin
            if (phase_ff[req_other] == ccthr_pkg::PH_PENDING) begin
               // chord: cancel the other corner, toggle game layer
               phase_in[req_other] = ccthr_pkg::PH_IDLE;
               wait_in[req_other]  = 16'd0;
               res_valid  = 1'b1;
               res.action = ccthr_pkg::ACT_TOGGLE;
               res.code   = 16'd0;
               res.corner = req_corner;
            end else begin
               // lone press (or repeat): restart countdown
               pending_in[req_corner] = req_code;
               phase_in[req_corner]   = ccthr_pkg::PH_PENDING;
               wait_in[req_corner]    = load_ticks;
            end
         end
         ccthr_pkg::OP_RELEASE: begin
            if (phase_ff[req_corner] == ccthr_pkg::PH_PENDING) begin
               phase_in[req_corner] = ccthr_pkg::PH_IDLE;
               wait_in[req_corner]  = 16'd0;
               res_valid  = 1'b1;
               res.action = ccthr_pkg::ACT_TAP;
               res.code   = ccthr_pkg::send_code(pending_ff[req_corner], req_caps,
                                                 minus_code_ff, under_code_ff);
               res.corner = req_corner;
            end else if (phase_ff[req_corner] == ccthr_pkg::PH_HELD) begin
               phase_in[req_corner] = ccthr_pkg::PH_IDLE;
               res_valid  = 1'b1;
               res.action = ccthr_pkg::ACT_UNREG;
               res.code   = held_ff[req_corner];
               res.corner = req_corner;
            end
         end
         ccthr_pkg::OP_TICK: begin
            // corner 0 wins if both expire; corner 1 then waits a tick at count 1
            for (int i = 0; i < 2; i++) begin
               if (phase_ff[i] == ccthr_pkg::PH_PENDING) begin
                  if (wait_ff[i] > 16'd1) begin
                     wait_in[i] = wait_ff[i] - 16'd1;
                  end else if (!tick_done) begin
                     tick_done   = 1'b1;
                     wait_in[i]  = 16'd0;
                     phase_in[i] = ccthr_pkg::PH_HELD;
                     held_in[i]  = ccthr_pkg::send_code(pending_ff[i], req_caps,
                                                        minus_code_ff, under_code_ff);
                     res_valid   = 1'b1;
                     res.action  = ccthr_pkg::ACT_REG;
                     res.code    = held_in[i];
                     res.corner  = 1'(i);
                  end
               end
            end
         end
         default: ;  // unused opcode: no effect
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            phase_ff[i]   <= ccthr_pkg::PH_IDLE;
            wait_ff[i]    <= 16'd0;
            pending_ff[i] <= 16'd0;
            held_ff[i]    <= 16'd0;
         end
      end else if (req_accept) begin
         for (int i = 0; i < 2; i++) begin
            phase_ff[i]   <= phase_in[i];
            wait_ff[i]    <= wait_in[i];
            pending_ff[i] <= pending_in[i];
            held_ff[i]    <= held_in[i];
         end
      end
   end

   // ---------------------------------------------------------------
   // Output queue: entry 0 is the head driving rsp_
   // ---------------------------------------------------------------
   ccthr_pkg::rsp_type q_ff [ccthr_pkg::QUEUE_DEPTH];
   ccthr_pkg::rsp_type q_in [ccthr_pkg::QUEUE_DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_tready = (cnt_ff != 2'(ccthr_pkg::QUEUE_DEPTH));
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = q_ff[0].code;
   assign rsp_tuser  = {q_ff[0].corner, q_ff[0].action};

   assign push = req_accept && res_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (pop && push) begin
         if (cnt_ff == 2'd1) begin
            q_in[0] = res;
         end else begin
            q_in[0] = q_ff[1];
            q_in[1] = res;
         end
      end else if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_ff - 2'd1;
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            q_in[0] = res;
         end else begin
            q_in[1] = res;
         end
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

endmodule

// ===== rtl/core/ccthr_checker.sv =====
// Port-level checks for the corner chord tap/hold resolver, bound to the top level.
// Depends on ccthr_pkg and corner_chord_tap_hold_resolver_macros.svh.
`include "corner_chord_tap_hold_resolver_macros.svh"

module ccthr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [3:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   logic        wr_ticks;    // chord_ticks write outside reset
   logic        rd_ticks;    // chord_ticks selected for read
   logic [31:0] wr_val;
   logic        rsp_stall;
   logic [18:0] rsp_word;
   logic        is_toggle;

   assign wr_ticks  = csr_psel && csr_penable && csr_pwrite && csr_pready && !reset &&
                      csr_paddr[3:2] == ccthr_pkg::REG_CHORD_TICKS;
   assign rd_ticks  = csr_paddr[3:2] == ccthr_pkg::REG_CHORD_TICKS;
   assign wr_val    = {16'd0, csr_pwdata[15:0]};
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tuser, rsp_tdata};
   assign is_toggle = rsp_tvalid && rsp_tuser[1:0] == ccthr_pkg::ACT_TOGGLE;

   // held result stays offered
   `CCTHR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid)

   // held result keeps its payload
   `CCTHR_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_word))

   // layer toggle carries no keycode
   `CCTHR_ASSERT_IMP(a_toggle_zero, clock, reset, is_toggle, rsp_tdata == 16'd0)

   // chord_ticks reads back what was just written
   `CCTHR_ASSERT_IMP(a_ticks_rdbk, clock, reset, $past(wr_ticks) && rd_ticks, csr_prdata == $past(wr_val))

   // queue is empty once reset drops
   `CCTHR_ASSERT_RAW(a_reset_empty, clock, !reset && $past(reset), !rsp_tvalid && req_tready)

endmodule

bind corner_chord_tap_hold_resolver ccthr_checker u_ccthr_checker (.*);
